// ----- hdl/ewma_adaptive_margin_assert.svh -----
// ----------------------------------------------------------------------------
// EWMA adaptive margin assertion macros
// Implication checks on the block clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef EWMA_ADAPTIVE_MARGIN_ASSERT_SVH
`define EWMA_ADAPTIVE_MARGIN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EAM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define EAM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EAM_ASSERT_IMP(lbl, ante, cons, msg)
`define EAM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/eam_pkg.sv -----
// ----------------------------------------------------------------------------
// EWMA adaptive margin package
// Widths, register codes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package eam_pkg;

	localparam int ELAPSED_W = 24;
	localparam int MARGIN_W  = 28;
	localparam int MEAN_W    = 24;
	localparam int STDDEV_W  = 24;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int MEANF_W   = 32;
	localparam int VARF_W    = 56;
	localparam int ACC_W     = 74;
	localparam int MULA_W    = 32;
	localparam int MULB_W    = 17;
	localparam int PROD_W    = MULA_W + MULB_W;
	localparam int SH_W      = 6;
	localparam int SIGMA_W   = 28;
	localparam int CNT_W     = 6;

	localparam logic [MARGIN_W-1:0] MARGIN_MAX = {MARGIN_W{1'b1}};
	localparam logic [ACC_W-1:0]    ROUND_HALF = ACC_W'(32768);
	localparam logic [VARF_W-1:0]   SQRT_BIT0  = {2'b01, {(VARF_W-2){1'b0}}};

	localparam logic [CNT_W-1:0] CNT_D2_LAST   = 6'd2;
	localparam logic [CNT_W-1:0] CNT_MEAN_LAST = 6'd2;
	localparam logic [CNT_W-1:0] CNT_VAR_LAST  = 6'd4;
	localparam logic [CNT_W-1:0] CNT_SQRT_LAST = 6'd28;
	localparam logic [CNT_W-1:0] CNT_PROD_LAST = 6'd1;
	localparam logic [CNT_W-1:0] CNT_DIV_LAST  = 6'd32;

	typedef enum logic [1:0] {
		ST_EWMA  = 2'd0,
		ST_RATIO = 2'd1,
		ST_FIXED = 2'd2,
		ST_INIT  = 2'd3
	} strategy_t;

	typedef enum logic [2:0] {
		REG_STRATEGY  = 3'd0,
		REG_ALPHA     = 3'd1,
		REG_SAFETY_K  = 3'd2,
		REG_MIN_MARG  = 3'd3,
		REG_INIT_MARG = 3'd4,
		REG_FIX_MARG  = 3'd5,
		REG_RATIO_NUM = 3'd6,
		REG_RATIO_DEN = 3'd7
	} reg_idx_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_D2   = 8'b0000_0010,
		S_MEAN = 8'b0000_0100,
		S_VAR  = 8'b0000_1000,
		S_SQRT = 8'b0001_0000,
		S_PROD = 8'b0010_0000,
		S_DIV  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	localparam strategy_t           RST_STRATEGY = ST_EWMA;
	localparam logic [15:0]         RST_ALPHA    = 16'd6554;
	localparam logic [11:0]         RST_SAFETY_K = 12'd512;
	localparam logic [ELAPSED_W-1:0] RST_MIN_MARG  = 24'd50;
	localparam logic [ELAPSED_W-1:0] RST_INIT_MARG = 24'd500;
	localparam logic [ELAPSED_W-1:0] RST_FIX_MARG  = 24'd500;
	localparam logic [7:0]          RST_RATIO_NUM = 8'd6;
	localparam logic [7:0]          RST_RATIO_DEN = 8'd5;

endpackage

// ----- hdl/eam_sample_if.sv -----
// ----------------------------------------------------------------------------
// EWMA adaptive margin sample channel
// Valid/ready channel carrying one measured execution time.
// ----------------------------------------------------------------------------
interface eam_sample_if;
	import eam_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] exec_time_us;

	modport source (output valid, output exec_time_us, input ready);
	modport sink (input valid, input exec_time_us, output ready);
endinterface

// ----- hdl/eam_margin_if.sv -----
// ----------------------------------------------------------------------------
// EWMA adaptive margin result channel
// Valid/ready channel carrying margin, mean and deviation.
// ----------------------------------------------------------------------------
interface eam_margin_if;
	import eam_pkg::*;

	logic                valid;
	logic                ready;
	logic [MARGIN_W-1:0] margin_us;
	logic [MEAN_W-1:0]   mean_us;
	logic [STDDEV_W-1:0] stddev_us;

	modport source (output valid, output margin_us, output mean_us, output stddev_us,
		input ready);
	modport sink (input valid, input margin_us, input mean_us, input stddev_us,
		output ready);
endinterface

// ----- hdl/ewma_adaptive_margin.sv -----
// ----------------------------------------------------------------------------
// EWMA adaptive margin
// Fixed-point EWMA mean/variance estimator with strategy-selected margin.
// ----------------------------------------------------------------------------
// Each sample transfer updates the Q24.8 mean and Q48.8 variance and yields one
// result: the margin, the integer mean and the integer deviation. A sample's
// work is nine multiply-accumulate passes through a single 32x17 multiplier,
// a 28-step square root and, for the last-times-ratio strategy only, a
// 32-step restoring divide, the last two sharing one 57-bit subtractor. The
// sample channel is ready only while the sequencer is idle; the result sits in
// an output register, so a new sample can transfer while the previous result
// waits, and the sequencer holds in its final step until that result is taken.
// Registers are written through the APB port at byte address 4*index. A write
// takes effect on the next sample only if the user makes it between samples;
// the block itself does not enforce this and uses a new value at once.
`include "ewma_adaptive_margin_assert.svh"

module ewma_adaptive_margin (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [eam_pkg::ADDR_W-1:0] paddr,
	input  logic [eam_pkg::DATA_W-1:0] pwdata,
	output logic [eam_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	eam_sample_if.sink                 sample_ch,
	eam_margin_if.source               margin_ch
);
	import eam_pkg::*;

	strategy_t            strategy_q;
	logic [15:0]          alpha_q;
	logic [11:0]          safety_k_q;
	logic [ELAPSED_W-1:0] min_margin_q;
	logic [ELAPSED_W-1:0] init_margin_q;
	logic [ELAPSED_W-1:0] fixed_margin_q;
	logic [7:0]           ratio_num_q;
	logic [7:0]           ratio_den_q;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MEANF_W-1:0]   mean_q;
	logic [VARF_W-1:0]    var_q;
	logic [ELAPSED_W-1:0] last_q;
	logic                 out_valid_q;

	logic                 nohist_q;
	logic [MEANF_W-1:0]   d_q;
	logic [VARF_W-1:0]    d2_q;
	logic [ACC_W-1:0]     acc_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SH_W-1:0]      sh_q;
	logic [VARF_W-1:0]    rem_q;
	logic [VARF_W-1:0]    root_q;
	logic [VARF_W-1:0]    bit_q;
	logic [SIGMA_W-1:0]   sigma_q;
	logic [MARGIN_W-1:0]  margin_q;
	logic [MEAN_W-1:0]    mean_out_q;
	logic [STDDEV_W-1:0]  stddev_q;

	logic                 apb_wr;
	reg_idx_t             reg_idx;
	logic                 accept;
	logic                 out_go;
	logic                 cnt_last;
	logic [MEANF_W-1:0]   x_in;
	logic [MEANF_W-1:0]   d_in;
	logic [MULB_W-1:0]    beta;
	logic [MULA_W-1:0]    mul_a;
	logic [MULB_W-1:0]    mul_b;
	logic [SH_W-1:0]      sh_d;
	logic [ACC_W-1:0]     acc_add;
	logic [VARF_W-1:0]    var_next;
	logic [MEANF_W-1:0]   mean_next;
	logic [VARF_W-1:0]    sub_a;
	logic [VARF_W-1:0]    sub_b;
	logic [VARF_W:0]      diff;
	logic                 ge;
	logic [8:0]           div_t;
	logic [MARGIN_W:0]    m0_raw;
	logic [MARGIN_W:0]    m0_flr;
	logic [MARGIN_W-1:0]  m0_sat;
	logic [MARGIN_W-1:0]  q_sat;
	logic [MARGIN_W-1:0]  margin_d;

	// configuration port
	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q     <= RST_STRATEGY;
			alpha_q        <= RST_ALPHA;
			safety_k_q     <= RST_SAFETY_K;
			min_margin_q   <= RST_MIN_MARG;
			init_margin_q  <= RST_INIT_MARG;
			fixed_margin_q <= RST_FIX_MARG;
			ratio_num_q    <= RST_RATIO_NUM;
			ratio_den_q    <= RST_RATIO_DEN;
		end else if (apb_wr) begin
			unique case (reg_idx)
				REG_STRATEGY:  strategy_q     <= strategy_t'(pwdata[1:0]);
				REG_ALPHA:     alpha_q        <= pwdata[15:0];
				REG_SAFETY_K:  safety_k_q     <= pwdata[11:0];
				REG_MIN_MARG:  min_margin_q   <= pwdata[ELAPSED_W-1:0];
				REG_INIT_MARG: init_margin_q  <= pwdata[ELAPSED_W-1:0];
				REG_FIX_MARG:  fixed_margin_q <= pwdata[ELAPSED_W-1:0];
				REG_RATIO_NUM: ratio_num_q    <= pwdata[7:0];
				REG_RATIO_DEN: ratio_den_q    <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STRATEGY:  prdata = DATA_W'(strategy_q);
			REG_ALPHA:     prdata = DATA_W'(alpha_q);
			REG_SAFETY_K:  prdata = DATA_W'(safety_k_q);
			REG_MIN_MARG:  prdata = DATA_W'(min_margin_q);
			REG_INIT_MARG: prdata = DATA_W'(init_margin_q);
			REG_FIX_MARG:  prdata = DATA_W'(fixed_margin_q);
			REG_RATIO_NUM: prdata = DATA_W'(ratio_num_q);
			REG_RATIO_DEN: prdata = DATA_W'(ratio_den_q);
		endcase
	end

	// handshakes
	assign sample_ch.ready     = (state_q == S_IDLE);
	assign accept              = sample_ch.valid && sample_ch.ready;
	assign out_go              = !out_valid_q || margin_ch.ready;
	assign margin_ch.valid     = out_valid_q;
	assign margin_ch.margin_us = margin_q;
	assign margin_ch.mean_us   = mean_out_q;
	assign margin_ch.stddev_us = stddev_q;

	assign x_in = {sample_ch.exec_time_us, 8'b0};
	assign d_in = (x_in >= mean_q) ? (x_in - mean_q) : (mean_q - x_in);
	assign beta = 17'h1_0000 - {1'b0, alpha_q};

	assign var_next  = nohist_q ? '0 : acc_q[71:16];
	assign mean_next = nohist_q ? {last_q, 8'b0} : acc_q[47:16];

	always_comb begin
		unique case (state_q)
			S_D2:    cnt_last = (cnt_q == CNT_D2_LAST);
			S_MEAN:  cnt_last = (cnt_q == CNT_MEAN_LAST);
			S_VAR:   cnt_last = (cnt_q == CNT_VAR_LAST);
			S_SQRT:  cnt_last = (cnt_q == CNT_SQRT_LAST);
			S_PROD:  cnt_last = (cnt_q == CNT_PROD_LAST);
			S_DIV:   cnt_last = (cnt_q == CNT_DIV_LAST);
			default: cnt_last = 1'b0;
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sh_d  = '0;
		unique case (state_q)
			S_D2: begin
				mul_a = d_q;
				if (cnt_q == 6'd0) begin
					mul_b = {1'b0, d_q[15:0]};
				end else begin
					mul_b = {1'b0, d_q[31:16]};
					sh_d  = 6'd16;
				end
			end
			S_MEAN: begin
				if (cnt_q == 6'd0) begin
					mul_a = {last_q, 8'b0};
					mul_b = {1'b0, alpha_q};
				end else begin
					mul_a = mean_q;
					mul_b = beta;
				end
			end
			S_VAR: begin
				unique case (cnt_q[1:0])
					2'd0: begin
						mul_a = d2_q[31:0];
						mul_b = {1'b0, alpha_q};
					end
					2'd1: begin
						mul_a = {8'b0, d2_q[55:32]};
						mul_b = {1'b0, alpha_q};
						sh_d  = 6'd32;
					end
					2'd2: begin
						mul_a = var_q[31:0];
						mul_b = beta;
					end
					2'd3: begin
						mul_a = {8'b0, var_q[55:32]};
						mul_b = beta;
						sh_d  = 6'd32;
					end
				endcase
			end
			S_PROD: begin
				if (strategy_q == ST_EWMA) begin
					mul_a = {4'b0, root_q[SIGMA_W-1:0]};
					mul_b = {5'b0, safety_k_q};
				end else begin
					mul_a = {8'b0, last_q};
					mul_b = {9'b0, ratio_num_q};
				end
			end
			default: ;
		endcase
	end

	assign acc_add = ACC_W'(prod_q) << sh_q;

	// shared subtractor: square root and divide steps
	assign div_t = {rem_q[7:0], root_q[31]};
	always_comb begin
		if (state_q == S_DIV) begin
			sub_a = {47'b0, div_t};
			sub_b = {48'b0, ratio_den_q};
		end else begin
			sub_a = rem_q;
			sub_b = root_q | bit_q;
		end
	end
	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge   = !diff[VARF_W];

	// margin select
	assign m0_raw = acc_q[40:12];
	assign m0_flr = (m0_raw < {5'b0, min_margin_q}) ? {5'b0, min_margin_q} : m0_raw;
	assign m0_sat = (m0_flr > {1'b0, MARGIN_MAX}) ? MARGIN_MAX : m0_flr[MARGIN_W-1:0];
	assign q_sat  = (root_q[31:0] > {4'b0, MARGIN_MAX}) ? MARGIN_MAX : root_q[MARGIN_W-1:0];

	always_comb begin
		unique case (strategy_q)
			ST_EWMA:  margin_d = (mean_q == '0) ? MARGIN_W'(init_margin_q) : m0_sat;
			ST_RATIO: begin
				if (last_q == '0) begin
					margin_d = MARGIN_W'(init_margin_q);
				end else if (ratio_den_q == '0) begin
					margin_d = MARGIN_MAX;
				end else begin
					margin_d = q_sat;
				end
			end
			ST_FIXED: margin_d = MARGIN_W'(fixed_margin_q);
			ST_INIT:  margin_d = MARGIN_W'(init_margin_q);
		endcase
	end

	// sequencer and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mean_q      <= '0;
			var_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_go) begin
				out_valid_q <= 1'b1;
			end else if (margin_ch.valid && margin_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q != S_IDLE && state_q != S_OUT) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= sample_ch.exec_time_us;
						cnt_q   <= '0;
						state_q <= S_D2;
					end
				end
				S_D2: begin
					if (cnt_last) state_q <= S_MEAN;
				end
				S_MEAN: begin
					if (cnt_last) state_q <= S_VAR;
				end
				S_VAR: begin
					if (cnt_q == 6'd0) mean_q <= mean_next;
					if (cnt_last) state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == 6'd0) var_q <= var_next;
					if (cnt_last) state_q <= S_PROD;
				end
				S_PROD: begin
					if (cnt_last) state_q <= (strategy_q == ST_RATIO) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (cnt_last) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_go) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		sh_q   <= sh_d;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					d_q      <= d_in;
					nohist_q <= (mean_q == '0);
				end
			end
			S_D2: begin
				acc_q <= (cnt_q == 6'd0) ? '0 : acc_q + acc_add;
			end
			S_MEAN: begin
				if (cnt_q == 6'd0) begin
					acc_q <= ROUND_HALF;
					d2_q  <= acc_q[63:8];
				end else begin
					acc_q <= acc_q + acc_add;
				end
			end
			S_VAR: begin
				acc_q <= (cnt_q == 6'd0) ? ROUND_HALF : acc_q + acc_add;
			end
			S_SQRT: begin
				if (cnt_q == 6'd0) begin
					rem_q  <= var_next;
					root_q <= '0;
					bit_q  <= SQRT_BIT0;
				end else begin
					if (ge) begin
						rem_q  <= diff[VARF_W-1:0];
						root_q <= (root_q >> 1) | bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			S_PROD: begin
				if (cnt_q == 6'd0) begin
					sigma_q <= root_q[SIGMA_W-1:0];
					acc_q   <= (strategy_q == ST_EWMA) ? ACC_W'({mean_q, 4'b0}) : '0;
				end else begin
					acc_q <= acc_q + acc_add;
				end
			end
			S_DIV: begin
				if (cnt_q == 6'd0) begin
					root_q <= {24'b0, acc_q[31:0]};
					rem_q  <= '0;
				end else begin
					rem_q  <= {48'b0, ge ? diff[7:0] : div_t[7:0]};
					root_q <= {24'b0, root_q[30:0], ge};
				end
			end
			S_OUT: begin
				if (out_go) begin
					margin_q   <= margin_d;
					mean_out_q <= mean_q[MEANF_W-1:8];
					stddev_q   <= sigma_q[SIGMA_W-1:4];
				end
			end
			default: ;
		endcase
	end

	`EAM_ASSERT_NXT(a_accept_starts, accept, state_q == S_D2, "transfer did not start")
	`EAM_ASSERT_IMP(a_div_ratio, state_q == S_DIV, strategy_q == ST_RATIO, "divide outside ratio")
	`EAM_ASSERT_IMP(a_nohist_var, (state_q == S_PROD) && nohist_q, var_q == '0, "variance kept")
	`EAM_ASSERT_NXT(a_out_load, (state_q == S_OUT) && out_go, margin_ch.valid, "result not loaded")

endmodule

// ----- tb/tb_ewma_adaptive_margin.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EWMA adaptive margin testbench
// Drives execution-time samples and APB register writes into the block and
// checks every margin/mean/deviation result against a fixed-point estimator
// kept in a scoreboard. Directed samples and settings come first. Random
// phases follow, each with its own register setting and, unless calm, random
// idle gaps on both channels; phase five adds a long result back-pressure stall.
// ----------------------------------------------------------------------------
module tb_ewma_adaptive_margin;
	import eam_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 1900;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 100;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin_us;
		logic [MEAN_W-1:0]   mean_us;
		logic [STDDEV_W-1:0] stddev_us;
	} margin_res_t;

	typedef enum int unsigned {
		SEQ_STEADY,
		SEQ_WIDE,
		SEQ_TINY
	} sample_mode_t;

	class ewma_tracker;
		strategy_t            strategy;
		logic [15:0]          alpha;
		logic [11:0]          k_q8;
		logic [ELAPSED_W-1:0] min_margin;
		logic [ELAPSED_W-1:0] init_margin;
		logic [ELAPSED_W-1:0] fixed_margin;
		logic [7:0]           ratio_num;
		logic [7:0]           ratio_den;
		logic [MEANF_W-1:0]   mean_fix;
		logic [VARF_W-1:0]    var_fix;
		logic [ELAPSED_W-1:0] last_sample;
		margin_res_t          pending_margins[$];
		int unsigned          errors;
		int unsigned          checked;
		bit [3:0]             strategies_seen;

		function new();
			strategy     = RST_STRATEGY;
			alpha        = RST_ALPHA;
			k_q8         = RST_SAFETY_K;
			min_margin   = RST_MIN_MARG;
			init_margin  = RST_INIT_MARG;
			fixed_margin = RST_FIX_MARG;
			ratio_num    = RST_RATIO_NUM;
			ratio_den    = RST_RATIO_DEN;
			mean_fix     = '0;
			var_fix      = '0;
			last_sample  = '0;
			errors       = 0;
			checked      = 0;
			strategies_seen = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_STRATEGY:  strategy = strategy_t'(val[1:0]);
				REG_ALPHA:     alpha = val[15:0];
				REG_SAFETY_K:  k_q8 = val[11:0];
				REG_MIN_MARG:  min_margin = val[23:0];
				REG_INIT_MARG: init_margin = val[23:0];
				REG_FIX_MARG:  fixed_margin = val[23:0];
				REG_RATIO_NUM: ratio_num = val[7:0];
				REG_RATIO_DEN: ratio_den = val[7:0];
				default: ;
			endcase
		endfunction

		// round-half-up blend of xa and ya with weight wa/65536
		function logic [63:0] blend(logic [15:0] wa, logic [63:0] xa, logic [63:0] ya);
			logic [79:0] acc;
			acc = 80'(wa) * 80'(xa) + (80'(17'h10000) - 80'(wa)) * 80'(ya) + 80'(32768);
			return acc[79:16];
		endfunction

		function logic [63:0] isqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] bitv;
			logic [63:0] rem;
			root = '0;
			rem  = v;
			bitv = 64'h4000_0000_0000_0000;
			while (bitv > rem)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rem >= root + bitv) begin
					rem  = rem - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		function void take_sample(logic [ELAPSED_W-1:0] v);
			logic [63:0] x;
			logic [63:0] d;
			logic [63:0] d2;
			logic [63:0] sigma;
			logic [63:0] root;
			logic [79:0] margin;
			margin_res_t res;
			x = 64'(v) << 8;
			if (mean_fix == 0) begin
				mean_fix = x[MEANF_W-1:0];
				var_fix  = '0;
			end else begin
				d  = (x >= 64'(mean_fix)) ? x - 64'(mean_fix) : 64'(mean_fix) - x;
				d2 = (d * d) >> 8;
				mean_fix = MEANF_W'(blend(alpha, x, 64'(mean_fix)));
				var_fix  = VARF_W'(blend(alpha, d2, 64'(var_fix)));
			end
			last_sample = v;
			sigma = isqrt(64'(var_fix));
			strategies_seen[strategy] = 1'b1;
			case (strategy)
				ST_EWMA: begin
					if (mean_fix == 0) begin
						margin = 80'(init_margin);
					end else begin
						margin = ((80'(mean_fix) << 4) + 80'(k_q8) * 80'(sigma)) >> 12;
						if (margin < 80'(min_margin))
							margin = 80'(min_margin);
					end
				end
				ST_RATIO: begin
					if (last_sample == 0)
						margin = 80'(init_margin);
					else if (ratio_den == 0)
						margin = 80'(MARGIN_MAX);
					else
						margin = (80'(last_sample) * 80'(ratio_num)) / 80'(ratio_den);
				end
				ST_FIXED: margin = 80'(fixed_margin);
				default:  margin = 80'(init_margin);
			endcase
			root = isqrt(64'(var_fix) >> 8);
			res.margin_us = (margin > 80'(MARGIN_MAX)) ? MARGIN_MAX : margin[MARGIN_W-1:0];
			res.mean_us   = mean_fix[31:8];
			res.stddev_us = root[STDDEV_W-1:0];
			pending_margins = {pending_margins, res};
		endfunction

		function void check_margin(margin_res_t got);
			margin_res_t want;
			if (pending_margins.size() == 0) begin
				errors++;
				$error("margin result with no sample outstanding: margin_us %0d", got.margin_us);
				return;
			end
			want = pending_margins.pop_front();
			checked++;
			if (got.margin_us !== want.margin_us) begin
				errors++;
				$error("margin_us: expected %0d, actual %0d", want.margin_us, got.margin_us);
			end
			if (got.mean_us !== want.mean_us) begin
				errors++;
				$error("mean_us: expected %0d, actual %0d", want.mean_us, got.mean_us);
			end
			if (got.stddev_us !== want.stddev_us) begin
				errors++;
				$error("stddev_us: expected %0d, actual %0d", want.stddev_us, got.stddev_us);
			end
		endfunction

		function int unsigned pending();
			return pending_margins.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	eam_sample_if smp ();
	eam_margin_if mrg ();

	ewma_tracker trk;
	bit          calm;
	bit          rx_hold;
	int unsigned stall_cycles;
	int unsigned n_writes;
	int unsigned n_samples;
	int unsigned n_holds;

	ewma_adaptive_margin dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample_ch (smp),
		.margin_ch (mrg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic int unsigned pick_level(input int unsigned maxv);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 0;
		if (r < 24)
			return maxv;
		if (r < 32)
			return 1;
		if (r < 66)
			return $urandom_range(0, (maxv > 4095) ? 4095 : maxv);
		return $urandom_range(0, maxv);
	endfunction

	function automatic logic [ELAPSED_W-1:0] pick_sample(input sample_mode_t mode,
		input logic [ELAPSED_W-1:0] base);
		int unsigned r;
		longint      span;
		longint      v;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 6 || mode == SEQ_WIDE)
			return ELAPSED_W'($urandom);
		if (mode == SEQ_TINY)
			return ELAPSED_W'($urandom_range(0, 15));
		span = longint'(base) / 8 + 1;
		v = longint'(base) + longint'($urandom_range(0, 32'(2 * span))) - span;
		if (v < 0)
			v = 0;
		if (v > 64'hFF_FFFF)
			v = 64'hFF_FFFF;
		return ELAPSED_W'(v);
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		trk.set_reg(idx, val);
		n_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [ELAPSED_W-1:0] v, input int unsigned gap);
		if (gap != 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid        <= 1'b1;
		smp.exec_time_us <= v;
		@(posedge clk);
		while (!smp.ready)
			@(posedge clk);
		trk.take_sample(v);
		n_samples++;
	endtask

	task automatic end_phase();
		smp.valid <= 1'b0;
		while (trk.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && mrg.valid && mrg.ready)
			trk.check_margin({mrg.margin_us, mrg.mean_us, mrg.stddev_us});
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (smp.valid && smp.ready) || (mrg.valid && mrg.ready))
			stall_cycles = 0;
		else
			stall_cycles = stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_ewma_adaptive_margin: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned off;
		int unsigned on;
		mrg.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold) begin
				mrg.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
				n_holds++;
			end
			off = pick_gap();
			if (off != 0) begin
				mrg.ready <= 1'b0;
				repeat (off) @(posedge clk);
			end
			on = calm ? 32 : $urandom_range(1, 8);
			mrg.ready <= 1'b1;
			repeat (on) @(posedge clk);
		end
	end

	initial begin
		int unsigned      sent;
		int unsigned      n_items;
		int unsigned      phase_no;
		int unsigned      r;
		sample_mode_t     mode;
		strategy_t        st;
		logic [15:0]      a;
		logic [ELAPSED_W-1:0] base;
		trk = new();
		stall_cycles = 0;
		n_writes  = 0;
		n_samples = 0;
		n_holds   = 0;
		calm      = 1'b0;
		rx_hold   = 1'b0;
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		smp.valid        <= 1'b0;
		smp.exec_time_us <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: zero samples without history, then a huge jump
		send_sample(24'd0, pick_gap());
		send_sample(24'd0, pick_gap());
		send_sample(24'd1000, pick_gap());
		send_sample(24'd1000, pick_gap());
		send_sample(24'd1300, pick_gap());
		send_sample(24'hFF_FFFF, pick_gap());
		send_sample(24'd0, pick_gap());
		send_sample(24'd7, pick_gap());
		end_phase();

		// ratio strategy: zero denominator, zero last sample, saturation
		write_reg(REG_STRATEGY, 32'(ST_RATIO));
		write_reg(REG_RATIO_NUM, 32'd255);
		write_reg(REG_RATIO_DEN, 32'd0);
		send_sample(24'hFF_FFFF, pick_gap());
		send_sample(24'd0, pick_gap());
		end_phase();
		write_reg(REG_RATIO_DEN, 32'd1);
		send_sample(24'hFF_FFFF, pick_gap());
		end_phase();
		write_reg(REG_RATIO_NUM, 32'd1);
		write_reg(REG_RATIO_DEN, 32'd255);
		send_sample(24'd254, pick_gap());
		end_phase();

		write_reg(REG_STRATEGY, 32'(ST_FIXED));
		write_reg(REG_FIX_MARG, 32'h00FF_FFFF);
		send_sample(24'd3, pick_gap());
		end_phase();
		write_reg(REG_STRATEGY, 32'(ST_INIT));
		write_reg(REG_INIT_MARG, 32'd0);
		send_sample(24'd9, pick_gap());
		end_phase();

		// heavy weight: mean rounds to zero, then large deviation with max k
		write_reg(REG_STRATEGY, 32'(ST_EWMA));
		write_reg(REG_ALPHA, 32'd65535);
		write_reg(REG_SAFETY_K, 32'd4095);
		write_reg(REG_MIN_MARG, 32'd0);
		send_sample(24'd1, pick_gap());
		send_sample(24'd1, pick_gap());
		send_sample(24'd0, pick_gap());
		send_sample(24'd0, pick_gap());
		send_sample(24'hFF_FFFF, pick_gap());
		send_sample(24'd0, pick_gap());
		end_phase();

		// alpha masked to zero freezes the estimate
		write_reg(REG_ALPHA, 32'hABCD_0000);
		write_reg(REG_MIN_MARG, 32'h00FF_FFFF);
		send_sample(24'd123, pick_gap());
		send_sample(24'hFF_FFFF, pick_gap());
		end_phase();

		sent = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_no++;
			calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 9);
			st = (r < 6) ? ST_EWMA : strategy_t'($urandom_range(0, 3));
			a = 16'(pick_level(65535));
			if (a == 0 && $urandom_range(0, 3) != 0)
				a = 16'd1;
			write_reg(REG_STRATEGY, ($urandom << 2) | 32'(st));
			write_reg(REG_ALPHA, ($urandom << 16) | 32'(a));
			write_reg(REG_SAFETY_K, ($urandom << 12) | pick_level(4095));
			write_reg(REG_MIN_MARG, ($urandom << 24) | pick_level(24'hFF_FFFF));
			write_reg(REG_INIT_MARG, ($urandom << 24) | pick_level(24'hFF_FFFF));
			write_reg(REG_FIX_MARG, ($urandom << 24) | pick_level(24'hFF_FFFF));
			write_reg(REG_RATIO_NUM, ($urandom << 8) | pick_level(255));
			write_reg(REG_RATIO_DEN, ($urandom << 8) | pick_level(255));
			r = $urandom_range(0, 99);
			mode = (r < 60) ? SEQ_STEADY : (r < 85) ? SEQ_WIDE : SEQ_TINY;
			base = ELAPSED_W'($urandom_range(1, (1 << $urandom_range(4, 24)) - 1));
			n_items = $urandom_range(30, 120);
			// hold results back while samples keep coming
			if (phase_no == 5) begin
				calm    = 1'b1;
				rx_hold = 1'b1;
			end
			repeat (n_items) begin
				send_sample(pick_sample(mode, base), pick_gap());
				sent++;
			end
			end_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (trk.pending() != 0) begin
			trk.errors++;
			$error("%0d margin results never arrived", trk.pending());
		end
		$display("Ran %0d samples, %0d results checked, %0d register writes, %0d settings.",
			n_samples, trk.checked, n_writes, phase_no + 8);
		$display("Strategies exercised (mask %b), %0d long result stall(s).",
			trk.strategies_seen, n_holds);
		if (trk.errors == 0)
			$display("tb_ewma_adaptive_margin: done, clean");
		else
			$display("tb_ewma_adaptive_margin: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/eam_pkg.sv
hdl/eam_sample_if.sv
hdl/eam_margin_if.sv
hdl/ewma_adaptive_margin.sv
tb/tb_ewma_adaptive_margin.sv
